@@ rtl/core/wmm_pkg.sv @@
// Shared types, constants and helpers for the window min/max filter.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package wmm_pkg;

	localparam int MAX_RADIUS = 3;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int SIDE_MAX  = 2 * MAX_RADIUS + 1;
	localparam int LINES_MAX = 2 * MAX_RADIUS;

	localparam int PIX_W     = 8;
	localparam int MODE_W    = 1;
	localparam int RAD_W     = 2;
	localparam int DIM_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam int COL_W  = $clog2(MAX_WIDTH);        // line-store address
	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);    // column count, holds the width itself
	localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);   // row count, holds the height itself
	localparam int LINE_W = $clog2(LINES_MAX);        // line bank select
	localparam int LCNT_W = $clog2(LINES_MAX + 1);    // number of buffered lines
	localparam int SCNT_W = $clog2(SIDE_MAX + 1);     // window side

	localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic              MODE_RESET   = 1'b0;
	localparam logic [RAD_W-1:0]  RADIUS_RESET = 2'd1;
	localparam logic [DIM_W-1:0]  DIM_RESET    = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_MODE   = 2'd0,
		CFG_KERNEL_RADIUS = 2'd1,
		CFG_IMAGE_WIDTH   = 2'd2,
		CFG_IMAGE_HEIGHT  = 2'd3
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [LINES_MAX-1:0] line_col_t;
	typedef pix_t [SIDE_MAX-1:0] win_vec_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered_value;
		logic             frame_end;
	} result_t;

	// Position of the current pixel, handed from the counters to the datapath.
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] bank;
		logic              work;
		logic              emit;
		logic              frame_end;
	} pos_t;

	// One step of a min or max reduction.
	function automatic pix_t pick(input pix_t a, input pix_t b, input logic want_max);
		if (want_max) begin
			return (b > a) ? b : a;
		end else begin
			return (b < a) ? b : a;
		end
	endfunction

endpackage

@@ rtl/core/window_min_max_filter_top.sv @@
// Top level of the streaming grayscale window min/max filter (erosion / dilation).
// Depends on wmm_pkg, wmm_pos_ctrl, wmm_line_buf and wmm_window.
//
// Pixels enter in raster order, one transaction per clock at full rate unless the
// output stalls, and each pixel passes line-store read, window shift, column reduction
// and row reduction into the output register. The rate of one pixel per cycle is
// set by the single-ported line banks, each read and written once per pixel, and
// by the two-level compare tree. A result is produced only where the
// (2r+1)x(2r+1) window lies inside the image, so a frame gives (height-2r) by
// (width-2r) results, the last one flagged by frame_end; an image smaller than the
// window gives none. frame_start on a pixel restarts the counts at that pixel, and
// pixels after the last row are taken and dropped until the next frame start.
// Configuration writes (mode, radius, width, height) are always accepted and must
// only be made while no pixel is in flight. There is no clearing pass after reset;
// line-store entries only reach a result after they were written in the current frame.
module window_min_max_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wmm_pkg::DIM_W-1:0]     cfg_data,

	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  wmm_pkg::pixel_t               pixel,

	output logic                          result_valid,
	input  logic                          result_stall,
	output wmm_pkg::result_t              result
);

	// configuration registers
	logic                        filter_mode_q;
	logic [wmm_pkg::RAD_W-1:0]   kernel_radius_q;
	logic [wmm_pkg::DIM_W-1:0]   image_width_q;
	logic [wmm_pkg::DIM_W-1:0]   image_height_q;

	logic [wmm_pkg::RAD_W-1:0]   r_eff;
	logic [wmm_pkg::LCNT_W-1:0]  lines;
	logic [wmm_pkg::SCNT_W-1:0]  side;

	wmm_pkg::pos_t               pos;
	logic                        accept;

	// stage 1: line-store read data and the pixel
	logic                        valid_s1;
	logic                        emit_s1;
	logic                        frame_end_s1;
	logic [wmm_pkg::LINE_W-1:0]  bank_s1;
	wmm_pkg::pix_t               pix_s1;
	wmm_pkg::line_col_t          rd_s1;

	// stage 2: window updated, only result-producing pixels continue
	logic                        valid_s2;
	logic                        frame_end_s2;
	wmm_pkg::win_vec_t           col_red;

	// stage 3: per-column reductions
	logic                        valid_s3;
	logic                        frame_end_s3;
	wmm_pkg::win_vec_t           col_red_s3;
	wmm_pkg::pix_t               win_red;

	// output register
	logic                        result_valid_q;
	wmm_pkg::result_t            result_q;

	logic ready_out, ready_s3, ready_s2, ready_s1;
	logic move_s1, move_s2, move_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q   <= wmm_pkg::MODE_RESET;
			kernel_radius_q <= wmm_pkg::RADIUS_RESET;
			image_width_q   <= wmm_pkg::DIM_RESET;
			image_height_q  <= wmm_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (wmm_pkg::cfg_idx_t'(cfg_index))
				wmm_pkg::CFG_FILTER_MODE: begin
					filter_mode_q <= cfg_data[0];
				end
				wmm_pkg::CFG_KERNEL_RADIUS: begin
					kernel_radius_q <= cfg_data[wmm_pkg::RAD_W-1:0];
				end
				wmm_pkg::CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data;
				end
				wmm_pkg::CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// radius saturates at the largest window the line store holds
	always_comb begin
		if (int'(kernel_radius_q) > wmm_pkg::MAX_RADIUS) begin
			r_eff = wmm_pkg::RAD_W'(wmm_pkg::MAX_RADIUS);
		end else begin
			r_eff = kernel_radius_q;
		end
		lines = wmm_pkg::LCNT_W'({r_eff, 1'b0});
		side  = wmm_pkg::SCNT_W'({r_eff, 1'b1});
	end

	// stall chain: a stage takes new data when empty or when it moves on
	assign ready_out   = !result_valid_q || !result_stall;
	assign ready_s3    = !valid_s3 || ready_out;
	assign ready_s2    = !valid_s2 || ready_s3;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign move_s1     = valid_s1 && ready_s2;
	assign move_s2     = valid_s2 && ready_s3;
	assign move_s3     = valid_s3 && ready_out;
	assign pixel_stall = !ready_s1;
	assign accept      = pixel_valid && ready_s1;

	wmm_pos_ctrl u_pos_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel        (pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.radius       (r_eff),
		.lines        (lines),
		.pos          (pos)
	);

	// the store read at the accept edge returns the column before this pixel's write
	wmm_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.wr_en   (accept && pos.work && (lines != '0)),
		.wr_bank (pos.bank),
		.addr    (pos.col),
		.wr_data (pixel.pixel_value),
		.rd_s1   (rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept && pos.work;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1      <= pos.emit;
			frame_end_s1 <= pos.frame_end;
			bank_s1      <= pos.bank;
			pix_s1       <= pixel.pixel_value;
		end
	end

	// window shifts as stage 1 drains; it stays frozen while stage 2 waits
	wmm_window u_window (
		.clk      (clk),
		.shift_en (move_s1),
		.lines    (lines),
		.side     (side),
		.want_max (filter_mode_q),
		.bank     (bank_s1),
		.pix      (pix_s1),
		.rd_col   (rd_s1),
		.col_red  (col_red)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			frame_end_s2 <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			col_red_s3   <= col_red;
			frame_end_s3 <= frame_end_s2;
		end
	end

	// reduce across the active columns
	always_comb begin
		win_red = filter_mode_q ? wmm_pkg::PIX_MIN : wmm_pkg::PIX_MAX;
		for (int c = 0; c < wmm_pkg::SIDE_MAX; c++) begin
			if (c < int'(side)) begin
				win_red = wmm_pkg::pick(win_red, col_red_s3[c], filter_mode_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ready_out) begin
			result_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) begin
			result_q.filtered_value <= win_red;
			result_q.frame_end      <= frame_end_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/core/wmm_pos_ctrl.sv @@
// Row/column counters and per-radius line pointers for the window min/max filter.
// Depends on wmm_pkg.
module wmm_pos_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  wmm_pkg::pixel_t            pixel,
	input  logic [wmm_pkg::DIM_W-1:0]  image_width,
	input  logic [wmm_pkg::DIM_W-1:0]  image_height,
	input  logic [wmm_pkg::RAD_W-1:0]  radius,
	input  logic [wmm_pkg::LCNT_W-1:0] lines,
	output wmm_pkg::pos_t              pos
);

	logic [wmm_pkg::WCNT_W-1:0] col_q, col_c, col_cur, col_inc, col_n, w_eff;
	logic [wmm_pkg::HCNT_W-1:0] row_q, row_c, row_cur, row_n, h_eff;
	// mod_q[i] = row count modulo 2*(i+1)
	logic [wmm_pkg::LINE_W-1:0] mod_q   [wmm_pkg::MAX_RADIUS];
	logic [wmm_pkg::LINE_W-1:0] mod_c   [wmm_pkg::MAX_RADIUS];
	logic [wmm_pkg::LINE_W-1:0] mod_cur [wmm_pkg::MAX_RADIUS];
	logic [wmm_pkg::LINE_W-1:0] mod_n   [wmm_pkg::MAX_RADIUS];
	logic skip_pre, wrap, skip, wrap_end;

	function automatic logic [wmm_pkg::LINE_W-1:0] inc_mod(
		input logic [wmm_pkg::LINE_W-1:0] m,
		input int                         i
	);
		return (m == wmm_pkg::LINE_W'(2 * i + 1)) ? '0 : m + 1'b1;
	endfunction

	always_comb begin
		if (image_width == '0) begin
			w_eff = wmm_pkg::WCNT_W'(1);
		end else if (int'(image_width) > wmm_pkg::MAX_WIDTH) begin
			w_eff = wmm_pkg::WCNT_W'(wmm_pkg::MAX_WIDTH);
		end else begin
			w_eff = wmm_pkg::WCNT_W'(image_width);
		end
		if (image_height == '0) begin
			h_eff = wmm_pkg::HCNT_W'(1);
		end else if (int'(image_height) > wmm_pkg::MAX_HEIGHT) begin
			h_eff = wmm_pkg::HCNT_W'(wmm_pkg::MAX_HEIGHT);
		end else begin
			h_eff = wmm_pkg::HCNT_W'(image_height);
		end
	end

	// frame start clears the counts before the pixel is placed
	always_comb begin
		col_c = pixel.frame_start ? '0 : col_q;
		row_c = pixel.frame_start ? '0 : row_q;
		for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
			mod_c[i] = pixel.frame_start ? '0 : mod_q[i];
		end

		skip_pre = (row_c >= h_eff);
		// width shrunk mid-row: wrap before placing
		wrap     = (col_c >= w_eff);
		col_cur  = wrap ? '0 : col_c;
		row_cur  = wrap ? row_c + 1'b1 : row_c;
		for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
			mod_cur[i] = wrap ? inc_mod(mod_c[i], i) : mod_c[i];
		end
		skip = skip_pre || (wrap && (row_cur >= h_eff));

		col_inc  = col_cur + 1'b1;
		wrap_end = (col_inc >= w_eff);

		if (skip_pre) begin
			col_n = col_c;
			row_n = row_c;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_n[i] = mod_c[i];
			end
		end else if (skip) begin
			col_n = '0;
			row_n = row_cur;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_n[i] = mod_cur[i];
			end
		end else if (wrap_end) begin
			col_n = '0;
			row_n = row_cur + 1'b1;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_n[i] = inc_mod(mod_cur[i], i);
			end
		end else begin
			col_n = col_inc;
			row_n = row_cur;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_n[i] = mod_cur[i];
			end
		end
	end

	always_comb begin
		pos.col  = wmm_pkg::COL_W'(col_cur);
		pos.bank = '0;
		for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
			if (int'(radius) == i + 1) begin
				pos.bank = mod_cur[i];
			end
		end
		pos.work      = !skip;
		pos.emit      = (int'(row_cur) >= int'(lines)) && (int'(col_cur) >= int'(lines));
		pos.frame_end = (row_cur == h_eff - 1'b1) && (col_cur == w_eff - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_q[i] <= '0;
			end
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
			for (int i = 0; i < wmm_pkg::MAX_RADIUS; i++) begin
				mod_q[i] <= mod_n[i];
			end
		end
	end

endmodule

@@ rtl/core/wmm_line_buf.sv @@
// Line store: one bank per buffered row, all banks read at the same column.
// Depends on wmm_pkg. Read data is registered; a read sees the data before a same-cycle write.
module wmm_line_buf (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic                       wr_en,
	input  logic [wmm_pkg::LINE_W-1:0] wr_bank,
	input  logic [wmm_pkg::COL_W-1:0]  addr,
	input  wmm_pkg::pix_t              wr_data,
	output wmm_pkg::line_col_t         rd_s1
);

	wmm_pkg::pix_t mem_q [wmm_pkg::LINES_MAX][wmm_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		for (int j = 0; j < wmm_pkg::LINES_MAX; j++) begin
			if (rd_en) begin
				rd_s1[j] <= mem_q[j][addr];
			end
			if (wr_en && (int'(wr_bank) == j)) begin
				mem_q[j][addr] <= wr_data;
			end
		end
	end

endmodule

@@ rtl/core/wmm_window.sv @@
// Square window shift registers and per-column min/max reduction.
// Depends on wmm_pkg. Column 0 is the newest; its rows come from the line banks and the pixel.
module wmm_window (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [wmm_pkg::LCNT_W-1:0] lines,
	input  logic [wmm_pkg::SCNT_W-1:0] side,
	input  logic                       want_max,
	input  logic [wmm_pkg::LINE_W-1:0] bank,
	input  wmm_pkg::pix_t              pix,
	input  wmm_pkg::line_col_t         rd_col,
	output wmm_pkg::win_vec_t          col_red
);

	wmm_pkg::win_vec_t window_q [wmm_pkg::SIDE_MAX];
	wmm_pkg::win_vec_t new_col;

	// row k takes bank (bank + k) mod lines, the bottom row takes the live pixel
	always_comb begin
		logic [wmm_pkg::LINE_W:0] sel;
		for (int k = 0; k < wmm_pkg::SIDE_MAX; k++) begin
			sel = {1'b0, bank} + (wmm_pkg::LINE_W + 1)'(k);
			if (int'(sel) >= int'(lines)) begin
				sel = sel - (wmm_pkg::LINE_W + 1)'(lines);
			end
			if (k < int'(lines)) begin
				new_col[k] = rd_col[sel[wmm_pkg::LINE_W-1:0]];
			end else if (k == int'(lines)) begin
				new_col[k] = pix;
			end else begin
				new_col[k] = window_q[0][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			window_q[0] <= new_col;
			for (int c = 1; c < wmm_pkg::SIDE_MAX; c++) begin
				window_q[c] <= window_q[c-1];
			end
		end
	end

	always_comb begin
		wmm_pkg::pix_t acc;
		for (int c = 0; c < wmm_pkg::SIDE_MAX; c++) begin
			acc = want_max ? wmm_pkg::PIX_MIN : wmm_pkg::PIX_MAX;
			for (int k = 0; k < wmm_pkg::SIDE_MAX; k++) begin
				if (k < int'(side)) begin
					acc = wmm_pkg::pick(acc, window_q[c][k], want_max);
				end
			end
			col_red[c] = acc;
		end
	end

endmodule

@@ tb/window_min_max_filter_top_tb.sv @@
// Self-checking testbench for window_min_max_filter_top: directed tests and random frames.
// A built-in window min/max predictor supplies the expected results.
// Depends on wmm_pkg and the window_min_max_filter_top RTL only.
module window_min_max_filter_top_tb;
	import wmm_pkg::*;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int DRAIN_CYCLES   = 8;     // four-stage pipeline, doubled
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for back-pressure
	localparam int RANDOM_PIXELS  = 1700;
	localparam int MAX_REPORTS    = 40;
	localparam int SCRIPT_LEN     = 38;

	// One row of the directed script: either a register write or a pixel transaction.
	// When pinned is set, want is the result read straight off the spec for that pixel.
	typedef struct packed {
		logic             is_cfg;
		cfg_idx_t         reg_idx;
		logic [DIM_W-1:0] reg_data;
		pixel_t           pix;
		logic             pinned;
		result_t          want;
	} script_row_t;

	localparam pixel_t  NO_PIX = '0;
	localparam result_t NO_RES = '0;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic             pixel_valid;
	logic             pixel_stall;
	pixel_t           pixel;
	logic             result_valid;
	logic             result_stall;
	result_t          result;

	// Register shadow, tracked from accepted write transactions.
	logic             cfg_mode   = MODE_RESET;
	logic [RAD_W-1:0] cfg_radius = RADIUS_RESET;
	logic [DIM_W-1:0] cfg_width  = DIM_RESET;
	logic [DIM_W-1:0] cfg_height = DIM_RESET;

	// Predictor state: line store, window and raster position.
	pix_t        line_mem [LINES_MAX][MAX_WIDTH];
	pix_t        win_mem  [SIDE_MAX][SIDE_MAX];
	int unsigned col_cnt = 0;
	int unsigned row_cnt = 0;

	result_t     pending_results [$];
	logic        pinned     = 1'b0;
	result_t     pinned_result = '0;

	int          send_idle_pct = 14;
	int          recv_idle_pct = 80;
	int          hold_cycles   = 0;
	int unsigned pixels_sent     = 0;
	int unsigned results_checked = 0;
	int unsigned reg_writes      = 0;
	int unsigned mismatch_count  = 0;

	// Directed script. Frame A runs without frame_start right after reset (counts start at
	// zero), min of a 3x3; a stray pixel after the last row must be dropped; frame B is the
	// 3x3 max; radius 0 passes pixels through; width/height 0 clamp to 1x1; a 2x2 image
	// under a 7x7 window gives nothing.
	script_row_t script [SCRIPT_LEN] = '{
		'{1'b1, CFG_IMAGE_WIDTH,   11'd3, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_HEIGHT,  11'd3, NO_PIX,           1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd255, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd255, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd0,   1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd255, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd255, 1'b0},  1'b1, '{8'd0, 1'b1}},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h55,  1'b0},  1'b0, NO_RES},
		'{1'b1, CFG_FILTER_MODE,   11'd1, NO_PIX,           1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd0,   1'b1},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd0,   1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd255, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd0,   1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd128, 1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'd0,   1'b0},  1'b1, '{8'd255, 1'b1}},
		'{1'b1, CFG_KERNEL_RADIUS, 11'd0, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_WIDTH,   11'd2, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_HEIGHT,  11'd1, NO_PIX,           1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'hA5,  1'b1},  1'b1, '{8'hA5, 1'b0}},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h5A,  1'b0},  1'b1, '{8'h5A, 1'b1}},
		'{1'b1, CFG_IMAGE_WIDTH,   11'd0, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_HEIGHT,  11'd0, NO_PIX,           1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h3C,  1'b1},  1'b1, '{8'h3C, 1'b1}},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'hC3,  1'b0},  1'b0, NO_RES},
		'{1'b1, CFG_KERNEL_RADIUS, 11'd3, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_WIDTH,   11'd2, NO_PIX,           1'b0, NO_RES},
		'{1'b1, CFG_IMAGE_HEIGHT,  11'd2, NO_PIX,           1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'hFF,  1'b1},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h00,  1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h81,  1'b0},  1'b0, NO_RES},
		'{1'b0, CFG_FILTER_MODE,   11'd0, '{8'h7E,  1'b0},  1'b0, NO_RES}
	};

	window_min_max_filter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Width and height registers saturate into 1..max.
	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	// Advance the filter by one accepted pixel; returns 1 and the result when the
	// window lies fully inside the image.
	function automatic bit predict_window(input pixel_t p, output result_t res);
		int unsigned rad, lines, side, w, h, col, row;
		pix_t        acc;
		rad   = cfg_radius;    // 2-bit field, never above MAX_RADIUS
		lines = 2 * rad;
		side  = lines + 1;
		w     = clamp_dim(cfg_width, MAX_WIDTH);
		h     = clamp_dim(cfg_height, MAX_HEIGHT);
		res   = '0;
		if (p.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		// past the last row: dropped until the next frame start
		if (row_cnt >= h) begin
			return 1'b0;
		end
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= h) begin
				return 1'b0;
			end
		end
		col = col_cnt;
		row = row_cnt;
		// shift the window right, new column enters at slot 0 (newest row at the bottom)
		for (int k = 0; k < SIDE_MAX; k++) begin
			for (int c = SIDE_MAX - 1; c > 0; c--) begin
				win_mem[k][c] = win_mem[k][c - 1];
			end
		end
		for (int unsigned k = 0; k < lines; k++) begin
			win_mem[k][0] = line_mem[(row + k) % lines][col];
		end
		win_mem[lines][0] = p.pixel_value;
		if (lines > 0) begin
			line_mem[row % lines][col] = p.pixel_value;
		end
		col_cnt = col + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt = row + 1;
		end
		if (row < lines || col < lines) begin
			return 1'b0;
		end
		acc = cfg_mode ? PIX_MIN : PIX_MAX;
		for (int unsigned k = 0; k < side; k++) begin
			for (int unsigned c = 0; c < side; c++) begin
				if (cfg_mode ? (win_mem[k][c] > acc) : (win_mem[k][c] < acc)) begin
					acc = win_mem[k][c];
				end
			end
		end
		res.filtered_value = acc;
		res.frame_end      = (row == h - 1) && (col == w - 1);
		return 1'b1;
	endfunction

	task automatic report(input string msg);
		if (mismatch_count < MAX_REPORTS) begin
			$display("%0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Monitor: everything sampled at the rising edge, pre-edge values.
	// Result check runs before the prediction so a spurious result is never matched
	// against a pixel taken in the same cycle.
	always @(posedge clk) begin : monitor
		result_t predicted;
		result_t wanted;
		bit      hit;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report($sformatf("result with nothing expected: value %0d, frame_end %0b",
						result.filtered_value, result.frame_end));
				end else begin
					wanted = pending_results.pop_front();
					if (result.filtered_value !== wanted.filtered_value) begin
						report($sformatf("filtered_value expected %0d, actual %0d",
							wanted.filtered_value, result.filtered_value));
					end
					if (result.frame_end !== wanted.frame_end) begin
						report($sformatf("frame_end expected %0b, actual %0b",
							wanted.frame_end, result.frame_end));
					end
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FILTER_MODE: begin
						cfg_mode = cfg_data[0];
					end
					CFG_KERNEL_RADIUS: begin
						cfg_radius = cfg_data[RAD_W-1:0];
					end
					CFG_IMAGE_WIDTH: begin
						cfg_width = cfg_data;
					end
					CFG_IMAGE_HEIGHT: begin
						cfg_height = cfg_data;
					end
					default: begin
					end
				endcase
				reg_writes++;
			end
			if (pixel_valid && !pixel_stall) begin
				hit = predict_window(pixel, predicted);
				if (pinned) begin
					// hand-written expectation; the predictor has to agree with it
					if (!hit || predicted !== pinned_result) begin
						report($sformatf("predictor gives %0b/%0d/%0b, script expects %0d/%0b",
							hit, predicted.filtered_value, predicted.frame_end,
							pinned_result.filtered_value, pinned_result.frame_end));
					end
					pending_results.push_back(pinned_result);
				end else if (hit) begin
					pending_results.push_back(predicted);
				end
			end
		end
	end

	// Receiver: random stall per cycle, or a long hold-off when one is requested.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Entered and left at a falling edge; valid is left high, the next call decides.
	task automatic send_pixel(input pixel_t p, input logic pin, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			pixel       <= {8'($urandom), 1'b1};   // junk while idle
			@(negedge clk);
		end
		pixel         <= p;
		pixel_valid   <= 1'b1;
		pinned        <= pin;
		pinned_result <= want;
		@(posedge clk);
		while (pixel_stall) begin
			@(posedge clk);
		end
		pixels_sent++;
		@(negedge clk);
	endtask

	// Write transaction; valid drops before the task returns so back-to-back writes
	// never lower and raise it in the same step.
	task automatic write_register(input cfg_idx_t idx, input logic [DIM_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for the block to go idle: all results in, then room for pixels that give none.
	task automatic settle();
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// count pixels of one frame (marked on the first), then strays past the last row
	task automatic send_frame(input int unsigned count, input int unsigned strays);
		pixel_t p;
		for (int unsigned i = 0; i < count + strays; i++) begin
			case ($urandom_range(0, 9))
				0: p.pixel_value = PIX_MIN;
				1: p.pixel_value = PIX_MAX;
				default: p.pixel_value = 8'($urandom);
			endcase
			p.frame_start = (i == 0);
			send_pixel(p, 1'b0, NO_RES);
		end
	endtask

	// New random settings between frames, then a few frames: mostly whole ones, some cut
	// short by the next frame start, some followed by stray pixels.
	task automatic random_phase();
		int unsigned rad, area, kind;
		settle();
		if ($urandom_range(0, 3) != 0) begin
			write_register(CFG_FILTER_MODE, DIM_W'($urandom));
		end
		if ($urandom_range(0, 3) != 0) begin
			write_register(CFG_KERNEL_RADIUS, DIM_W'($urandom));
		end
		rad = cfg_radius;
		if ($urandom_range(0, 3) != 0) begin
			write_register(CFG_IMAGE_WIDTH, DIM_W'($urandom_range(0, 2 * rad + 15)));
		end
		if ($urandom_range(0, 3) != 0) begin
			write_register(CFG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 2 * rad + 6)));
		end
		area = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
		repeat ($urandom_range(1, 3)) begin
			kind = $urandom_range(0, 99);
			if (kind < 15 && area > 1) begin
				send_frame($urandom_range(1, area - 1), 0);
			end else if (kind >= 85) begin
				send_frame(area, $urandom_range(1, 6));
			end else begin
				send_frame(area, 0);
			end
		end
	endtask

	initial begin
		int unsigned base;
		pixel_t      p;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_FILTER_MODE;
		cfg_data    = '0;
		pixel_valid = 1'b0;
		pixel       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed script; every register write waits for the block to drain
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_register(script[i].reg_idx, script[i].reg_data);
			end else begin
				send_pixel(script[i].pix, script[i].pinned, script[i].want);
			end
		end

		base = pixels_sent;

		// back-pressure: receiver holds off while a whole frame is offered, so the
		// pipeline fills and the block has to stall its pixel input
		settle();
		write_register(CFG_FILTER_MODE, DIM_W'($urandom));
		write_register(CFG_KERNEL_RADIUS, 11'd1);
		write_register(CFG_IMAGE_WIDTH, 11'd20);
		write_register(CFG_IMAGE_HEIGHT, 11'd10);
		hold_cycles = HOLD_CYCLES;
		send_frame(200, 0);

		// settings changed inside a frame: mode flip, shorter rows, fewer rows;
		// the row in progress wraps as soon as it reaches the new width
		settle();
		write_register(CFG_IMAGE_WIDTH, 11'd16);
		send_frame(5 * 16 + 7, 0);
		settle();
		write_register(CFG_FILTER_MODE, DIM_W'(cfg_mode ^ 1'b1));
		write_register(CFG_IMAGE_WIDTH, 11'd9);
		write_register(CFG_IMAGE_HEIGHT, 11'd7);
		repeat (40) begin
			p.pixel_value = 8'($urandom);
			p.frame_start = 1'b0;
			send_pixel(p, 1'b0, NO_RES);
		end

		// random frames: sender-light/receiver-heavy idling, then reversed, then none
		while (pixels_sent - base < RANDOM_PIXELS) begin
			if (pixels_sent - base >= 2 * RANDOM_PIXELS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (pixels_sent - base >= RANDOM_PIXELS / 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 14;
			end
			random_phase();
		end

		// largest sizes, one frame each: full-width rows through the line store
		// (width above range saturates), then full height with a one-pixel row
		settle();
		write_register(CFG_KERNEL_RADIUS, 11'd1);
		write_register(CFG_IMAGE_WIDTH, 11'd2047);
		write_register(CFG_IMAGE_HEIGHT, 11'd3);
		send_frame(3 * MAX_WIDTH, 0);
		settle();
		write_register(CFG_KERNEL_RADIUS, 11'd0);
		write_register(CFG_IMAGE_WIDTH, 11'd1);
		write_register(CFG_IMAGE_HEIGHT, 11'd1024);
		send_frame(MAX_HEIGHT, 2);

		settle();
		$display("Run covered %0d pixel transactions, %0d checked results and %0d register writes,",
			pixels_sent, results_checked, reg_writes);
		$display("min and max windows of radius 0 to 3, images from 1x1 up to 1024 wide or tall.");
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still expected",
			CYCLE_LIMIT, pending_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
